[hdl/csv_field_tokenizer_top_defines.svh]
// Assertion macros shared by the CSV field tokenizer modules.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef CSV_FIELD_TOKENIZER_TOP_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CSVT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/csvt_pkg.sv]
// Types and constants for the CSV field tokenizer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package csvt_pkg;

  localparam logic [7:0] QUOTE_BYTE    = 8'h22;
  localparam logic [7:0] CR_BYTE       = 8'h0D;
  localparam logic [7:0] LF_BYTE       = 8'h0A;
  localparam logic [7:0] DEFAULT_DELIM = 8'h2C;

  typedef enum logic [2:0] {
    MODE_REC_START  = 3'd0,
    MODE_FLD_START  = 3'd1,
    MODE_UNQUOTED   = 3'd2,
    MODE_QUOTED     = 3'd3,
    MODE_QUOTE_SEEN = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CONTENT    = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_RECORD_END = 2'd2
  } kind_t;

  // Results caused by one input byte: up to three tokens, at most one content byte.
  typedef struct packed {
    logic [1:0]      cnt;
    kind_t [2:0]     kinds;
    logic [7:0]      data_byte;
  } bundle_t;

endpackage

[hdl/csvt_front.sv]
// Front end of the CSV field tokenizer: holds the delimiter and parse mode,
// classifies each byte and builds the bundle of tokens it causes. Uses csvt_pkg.
module csvt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // in_byte[7:0]
  input  logic               s_tlast,   // is_final
  input  logic               q_full,
  output logic               q_push,
  output csvt_pkg::bundle_t  q_bundle
);

  logic [7:0]      delim;
  csvt_pkg::mode_t mode;
  csvt_pkg::mode_t mode_mid;
  csvt_pkg::mode_t mode_next;
  logic            is_q;
  logic            is_d;
  logic            is_lb;
  logic            accept;
  logic [1:0]      n;
  csvt_pkg::kind_t k0;
  csvt_pkg::kind_t k1;
  csvt_pkg::kind_t k2;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  assign is_q  = (s_tdata == csvt_pkg::QUOTE_BYTE);
  assign is_d  = (s_tdata == delim);
  assign is_lb = (s_tdata == csvt_pkg::CR_BYTE) || (s_tdata == csvt_pkg::LF_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      delim <= csvt_pkg::DEFAULT_DELIM;
      mode  <= csvt_pkg::MODE_REC_START;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delim <= cfg_data;
      end
      if (accept) begin
        mode <= mode_next;
      end
    end
  end

  always_comb begin
    case (mode)
      csvt_pkg::MODE_FLD_START: begin
        if (is_q) mode_mid = csvt_pkg::MODE_QUOTED;
        else if (is_d) mode_mid = csvt_pkg::MODE_FLD_START;
        else if (is_lb) mode_mid = csvt_pkg::MODE_REC_START;
        else mode_mid = csvt_pkg::MODE_UNQUOTED;
      end
      csvt_pkg::MODE_UNQUOTED: begin
        if (is_d) mode_mid = csvt_pkg::MODE_FLD_START;
        else if (is_lb) mode_mid = csvt_pkg::MODE_REC_START;
        else mode_mid = csvt_pkg::MODE_UNQUOTED;
      end
      csvt_pkg::MODE_QUOTED: begin
        if (is_q) mode_mid = csvt_pkg::MODE_QUOTE_SEEN;
        else mode_mid = csvt_pkg::MODE_QUOTED;
      end
      csvt_pkg::MODE_QUOTE_SEEN: begin
        if (is_q) mode_mid = csvt_pkg::MODE_QUOTED;
        else if (is_d) mode_mid = csvt_pkg::MODE_FLD_START;
        else if (is_lb) mode_mid = csvt_pkg::MODE_REC_START;
        else mode_mid = csvt_pkg::MODE_UNQUOTED;
      end
      default: begin
        if (is_lb) mode_mid = csvt_pkg::MODE_REC_START;
        else if (is_q) mode_mid = csvt_pkg::MODE_QUOTED;
        else if (is_d) mode_mid = csvt_pkg::MODE_FLD_START;
        else mode_mid = csvt_pkg::MODE_UNQUOTED;
      end
    endcase
    mode_next = s_tlast ? csvt_pkg::MODE_REC_START : mode_mid;
  end

  always_comb begin
    n  = 2'd0;
    k0 = csvt_pkg::KIND_CONTENT;
    k1 = csvt_pkg::KIND_CONTENT;
    k2 = csvt_pkg::KIND_CONTENT;
    case (mode)
      csvt_pkg::MODE_FLD_START, csvt_pkg::MODE_UNQUOTED: begin
        if (is_q && mode == csvt_pkg::MODE_FLD_START) begin
          n = 2'd0;
        end else if (is_d) begin
          n  = 2'd1;
          k0 = csvt_pkg::KIND_FIELD_END;
        end else if (is_lb) begin
          n  = 2'd1;
          k0 = csvt_pkg::KIND_RECORD_END;
        end else begin
          n  = 2'd1;
        end
      end
      csvt_pkg::MODE_QUOTED: begin
        if (!is_q) begin
          n = 2'd1;
        end
      end
      csvt_pkg::MODE_QUOTE_SEEN: begin
        if (is_q) begin
          n = 2'd1;
        end else if (is_d) begin
          n  = 2'd1;
          k0 = csvt_pkg::KIND_FIELD_END;
        end else if (is_lb) begin
          n  = 2'd1;
          k0 = csvt_pkg::KIND_RECORD_END;
        end else begin
          n  = 2'd2;
          k0 = csvt_pkg::KIND_FIELD_END;
        end
      end
      default: begin
        if (is_lb || is_q) begin
          n = 2'd0;
        end else if (is_d) begin
          n  = 2'd1;
          k0 = csvt_pkg::KIND_FIELD_END;
        end else begin
          n = 2'd1;
        end
      end
    endcase
    // On the last byte a trailing delimiter closes the record, and an open field is closed.
    if (s_tlast) begin
      if (mode_mid == csvt_pkg::MODE_FLD_START) begin
        if (n != 2'd0) begin
          k0 = csvt_pkg::KIND_RECORD_END;
        end
      end else if (mode_mid != csvt_pkg::MODE_REC_START) begin
        case (n)
          2'd0:    k0 = csvt_pkg::KIND_RECORD_END;
          2'd1:    k1 = csvt_pkg::KIND_RECORD_END;
          default: k2 = csvt_pkg::KIND_RECORD_END;
        endcase
        n = n + 2'd1;
      end
    end
  end

  assign q_push             = accept && (n != 2'd0);
  assign q_bundle.cnt       = n;
  assign q_bundle.kinds[0]  = k0;
  assign q_bundle.kinds[1]  = k1;
  assign q_bundle.kinds[2]  = k2;
  assign q_bundle.data_byte = s_tdata;

endmodule

[hdl/csvt_queue.sv]
// Short queue of token bundles between the tokenizer front and back ends.
// Uses csvt_pkg for the bundle type.
`include "csv_field_tokenizer_top_defines.svh"
module csvt_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  csvt_pkg::bundle_t  push_bundle,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output csvt_pkg::bundle_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csvt_pkg::bundle_t entries [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CSVT_ASSERT_IMPL(a_count_range, 1'b1, count <= CW'(DEPTH), "queue count beyond depth")
  `CSVT_ASSERT_IMPL(a_no_push_full, push, !full || pop, "push into a full queue")
  `CSVT_ASSERT_NEXT(a_pop_count, pop && !push, count == $past(count) - 1'b1, "pop count slip")

endmodule

[hdl/csvt_back.sv]
// Back end of the CSV field tokenizer: walks the head bundle one token per beat.
// Uses csvt_pkg for the bundle and token kind types.
`include "csv_field_tokenizer_top_defines.svh"
module csvt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  csvt_pkg::bundle_t  q_head,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // content_byte[7:0]
  output logic [1:0]         m_tuser,   // token_kind[1:0]
  output logic               m_tlast    // run_end
);

  logic [1:0]      idx;
  csvt_pkg::kind_t kind;
  logic            last_slot;

  always_comb begin
    case (idx)
      2'd0:    kind = q_head.kinds[0];
      2'd1:    kind = q_head.kinds[1];
      default: kind = q_head.kinds[2];
    endcase
  end

  assign last_slot = (idx == q_head.cnt - 2'd1);
  assign m_tvalid  = !q_empty;
  assign m_tuser   = kind;
  assign m_tdata   = (kind == csvt_pkg::KIND_CONTENT) ? q_head.data_byte : 8'd0;
  assign m_tlast   = last_slot;
  assign q_pop     = m_tvalid && m_tready && last_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      idx <= last_slot ? 2'd0 : idx + 2'd1;
    end
  end

  `CSVT_ASSERT_IMPL(a_bundle_nonempty, m_tvalid, q_head.cnt != 2'd0, "empty bundle in queue")
  `CSVT_ASSERT_IMPL(a_idx_in_bundle, m_tvalid, idx < q_head.cnt, "token index past bundle")
  `CSVT_ASSERT_NEXT(a_rest_pending, m_tvalid && m_tready && !m_tlast, m_tvalid, "bundle lost")

endmodule

[hdl/csv_field_tokenizer_top.sv]
// Top level of the CSV field tokenizer: front end, bundle queue and back end.
// Depends on csvt_pkg, csvt_front, csvt_queue and csvt_back.
//
//   channel | dir | tdata             | tuser           | tlast
//   s_*     | in  | in_byte[7:0]      | -               | is_final
//   m_*     | out | content_byte[7:0] | token_kind[1:0] | run_end
//   cfg_*   | in  | field_delimiter   | -               | -
//
// One byte is accepted per cycle while the queue has room; each gives zero to three tokens.
// The back end sends one token per cycle while m_tready is high.
// Synchronous reset sets the delimiter to comma and the parse mode to record start.
// A stalled output fills the queue of QUEUE_DEPTH bundles before s_tready drops.
module csv_field_tokenizer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,    // field_delimiter[7:0]
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // in_byte[7:0]
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // content_byte[7:0]
  output logic [1:0] m_tuser,     // token_kind[1:0]
  output logic       m_tlast
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  csvt_pkg::bundle_t q_in;
  csvt_pkg::bundle_t q_head;

  csvt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_bundle (q_in)
  );

  csvt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_bundle(q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  csvt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

[dv/tb_csv_field_tokenizer_top.sv]
// Self-checking testbench for csv_field_tokenizer_top: directed CSV text, then random records
// and noise under several delimiters, with random gaps and stalls on both streams.
// Depends on csvt_pkg and the csv_field_tokenizer_top RTL.
module tb_csv_field_tokenizer_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_IDLE = 17;
  localparam int PHASE_BYTES = 34;

  typedef struct packed {
    csvt_pkg::kind_t kind;
    logic [7:0]      data;
    logic            last;
  } token_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    int         gap;
  } csv_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  csv_byte_t       csv_bytes[$];
  token_t          pending_tokens[$];
  csv_byte_t       next_byte;
  bit              have_next = 1'b0;
  bit              in_taken = 1'b0;
  bit              out_taken = 1'b0;
  bit              gaps_on = 1'b0;
  bit              stalls_on = 1'b0;
  int              stall_left = 0;
  int              errors = 0;
  int              cycle_count = 0;
  int              bytes_queued = 0;
  logic [7:0]      gen_delim = csvt_pkg::DEFAULT_DELIM;
  logic [7:0]      track_delim;
  csvt_pkg::mode_t track_mode;

  csv_field_tokenizer_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // Works out the tokens that one accepted byte gives and advances the tracked parse mode.
  function automatic void predict_tokens(logic [7:0] b, logic fin);
    token_t          toks[$];
    csvt_pkg::mode_t m;
    m = track_mode;
    case (m)
      csvt_pkg::MODE_FLD_START: begin
        if (b == csvt_pkg::QUOTE_BYTE) m = csvt_pkg::MODE_QUOTED;
        else if (b == track_delim) toks.push_back('{csvt_pkg::KIND_FIELD_END, 8'h00, 1'b0});
        else if (b == csvt_pkg::CR_BYTE || b == csvt_pkg::LF_BYTE) begin
          toks.push_back('{csvt_pkg::KIND_RECORD_END, 8'h00, 1'b0});
          m = csvt_pkg::MODE_REC_START;
        end else begin
          toks.push_back('{csvt_pkg::KIND_CONTENT, b, 1'b0});
          m = csvt_pkg::MODE_UNQUOTED;
        end
      end
      csvt_pkg::MODE_UNQUOTED: begin
        if (b == track_delim) begin
          toks.push_back('{csvt_pkg::KIND_FIELD_END, 8'h00, 1'b0});
          m = csvt_pkg::MODE_FLD_START;
        end else if (b == csvt_pkg::CR_BYTE || b == csvt_pkg::LF_BYTE) begin
          toks.push_back('{csvt_pkg::KIND_RECORD_END, 8'h00, 1'b0});
          m = csvt_pkg::MODE_REC_START;
        end else toks.push_back('{csvt_pkg::KIND_CONTENT, b, 1'b0});
      end
      csvt_pkg::MODE_QUOTED: begin
        if (b == csvt_pkg::QUOTE_BYTE) m = csvt_pkg::MODE_QUOTE_SEEN;
        else toks.push_back('{csvt_pkg::KIND_CONTENT, b, 1'b0});
      end
      csvt_pkg::MODE_QUOTE_SEEN: begin
        if (b == csvt_pkg::QUOTE_BYTE) begin
          toks.push_back('{csvt_pkg::KIND_CONTENT, csvt_pkg::QUOTE_BYTE, 1'b0});
          m = csvt_pkg::MODE_QUOTED;
        end else if (b == track_delim) begin
          toks.push_back('{csvt_pkg::KIND_FIELD_END, 8'h00, 1'b0});
          m = csvt_pkg::MODE_FLD_START;
        end else if (b == csvt_pkg::CR_BYTE || b == csvt_pkg::LF_BYTE) begin
          toks.push_back('{csvt_pkg::KIND_RECORD_END, 8'h00, 1'b0});
          m = csvt_pkg::MODE_REC_START;
        end else begin
          toks.push_back('{csvt_pkg::KIND_FIELD_END, 8'h00, 1'b0});
          toks.push_back('{csvt_pkg::KIND_CONTENT, b, 1'b0});
          m = csvt_pkg::MODE_UNQUOTED;
        end
      end
      default: begin
        if (b == csvt_pkg::CR_BYTE || b == csvt_pkg::LF_BYTE) m = csvt_pkg::MODE_REC_START;
        else if (b == csvt_pkg::QUOTE_BYTE) m = csvt_pkg::MODE_QUOTED;
        else if (b == track_delim) begin
          toks.push_back('{csvt_pkg::KIND_FIELD_END, 8'h00, 1'b0});
          m = csvt_pkg::MODE_FLD_START;
        end else begin
          toks.push_back('{csvt_pkg::KIND_CONTENT, b, 1'b0});
          m = csvt_pkg::MODE_UNQUOTED;
        end
      end
    endcase
    if (fin) begin
      // A delimiter on the last byte closes the record instead of opening an empty field.
      if (m == csvt_pkg::MODE_FLD_START) begin
        if (toks.size() > 0) toks[toks.size() - 1].kind = csvt_pkg::KIND_RECORD_END;
      end else if (m == csvt_pkg::MODE_UNQUOTED || m == csvt_pkg::MODE_QUOTED ||
                   m == csvt_pkg::MODE_QUOTE_SEEN) begin
        toks.push_back('{csvt_pkg::KIND_RECORD_END, 8'h00, 1'b0});
      end
      m = csvt_pkg::MODE_REC_START;
    end
    if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
    foreach (toks[i]) pending_tokens.push_back(toks[i]);
    track_mode = m;
  endfunction

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      in_taken = 1'b0;
      out_taken = 1'b0;
      track_mode = csvt_pkg::MODE_REC_START;
      track_delim = csvt_pkg::DEFAULT_DELIM;
      pending_tokens.delete();
    end else begin
      in_taken = s_tvalid && s_tready;
      out_taken = m_tvalid && m_tready;
      if (in_taken) predict_tokens(s_tdata, s_tlast);
      if (cfg_valid && cfg_ready) track_delim = cfg_data;
      if (out_taken) begin
        if (pending_tokens.size() == 0) begin
          flag_error($sformatf("unexpected beat: kind %0d data %02h last %0b",
                               m_tuser, m_tdata, m_tlast));
        end else begin
          want = pending_tokens.pop_front();
          if (m_tuser !== want.kind || m_tdata !== want.data || m_tlast !== want.last)
            flag_error($sformatf("mismatch: expected kind %0d data %02h last %0b, got %0d %02h %0b",
                                 want.kind, want.data, want.last, m_tuser, m_tdata, m_tlast));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      have_next = 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (!have_next && csv_bytes.size() > 0) begin
        next_byte = csv_bytes.pop_front();
        have_next = 1'b1;
      end
      if (have_next && next_byte.gap > 0) begin
        next_byte.gap--;
        s_tvalid <= 1'b0;
      end else if (have_next) begin
        s_tvalid <= 1'b1;
        s_tdata <= next_byte.data;
        s_tlast <= next_byte.fin;
        have_next = 1'b0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_taken) stall_left = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic fin);
    csv_byte_t item;
    item.data = b;
    item.fin = fin;
    item.gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    csv_bytes.push_back(item);
    bytes_queued++;
  endtask

  task automatic settle();
    while (csv_bytes.size() != 0 || have_next || s_tvalid || pending_tokens.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_delim(logic [7:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_delim = d;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_plain(bit first);
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
    end while (b == gen_delim || b == csvt_pkg::CR_BYTE || b == csvt_pkg::LF_BYTE ||
               (first && b == csvt_pkg::QUOTE_BYTE));
    return b;
  endfunction

  task automatic gen_record();
    int         nf;
    int         len;
    logic [7:0] b;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) push_byte(gen_delim, 1'b0);
      len = $urandom_range(0, 5);
      if ($urandom_range(0, 2) == 0) begin
        push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 5))
            0: b = gen_delim;
            1: b = csvt_pkg::QUOTE_BYTE;
            2: b = $urandom_range(0, 1) ? csvt_pkg::CR_BYTE : csvt_pkg::LF_BYTE;
            default: b = pick_plain(1'b0);
          endcase
          push_byte(b, 1'b0);
          if (b == csvt_pkg::QUOTE_BYTE) push_byte(b, 1'b0);
        end
        push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
      end else begin
        for (int i = 0; i < len; i++) push_byte(pick_plain(i == 0), 1'b0);
      end
    end
    case ($urandom_range(0, 9))
      0: push_byte(pick_plain(1'b0), 1'b1);
      1: push_byte(gen_delim, 1'b1);
      2, 3, 4: push_byte(csvt_pkg::LF_BYTE, 1'b0);
      5, 6, 7: begin
        push_byte(csvt_pkg::CR_BYTE, 1'b0);
        push_byte(csvt_pkg::LF_BYTE, 1'b0);
      end
      default: push_byte(csvt_pkg::CR_BYTE, 1'b0);
    endcase
  endtask

  task automatic gen_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: b = gen_delim;
        1: b = csvt_pkg::QUOTE_BYTE;
        2: b = csvt_pkg::CR_BYTE;
        3: b = csvt_pkg::LF_BYTE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_byte(b, $urandom_range(0, 11) == 0);
    end
  endtask

  task automatic run_phase(logic [7:0] d, int idx);
    settle();
    write_delim(d);
    gaps_on = idx[0];
    stalls_on = idx[1];
    bytes_queued = 0;
    while (bytes_queued < PHASE_BYTES) begin
      if ($urandom_range(0, 7) == 0) gen_noise();
      else gen_record();
    end
  endtask

  initial begin
    logic [7:0] phase_delims[10];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_delim(csvt_pkg::DEFAULT_DELIM);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    push_byte(csvt_pkg::LF_BYTE, 1'b0);
    push_byte(csvt_pkg::CR_BYTE, 1'b0);
    push_byte("a", 1'b0);
    push_byte(",", 1'b0);
    push_byte(",", 1'b0);
    push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
    push_byte(",", 1'b0);
    push_byte(csvt_pkg::CR_BYTE, 1'b0);
    push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
    push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
    push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
    push_byte("x", 1'b0);
    push_byte(csvt_pkg::CR_BYTE, 1'b0);
    push_byte(",", 1'b0);
    push_byte(csvt_pkg::LF_BYTE, 1'b0);
    push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
    push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
    push_byte(csvt_pkg::LF_BYTE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(",", 1'b1);
    push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
    push_byte("q", 1'b0);
    push_byte(csvt_pkg::QUOTE_BYTE, 1'b0);
    push_byte("y", 1'b1);
    push_byte(csvt_pkg::QUOTE_BYTE, 1'b1);
    push_byte(csvt_pkg::LF_BYTE, 1'b1);

    phase_delims = '{8'hFF, 8'h00, csvt_pkg::QUOTE_BYTE, csvt_pkg::CR_BYTE, csvt_pkg::LF_BYTE,
                     8'h3B, 8'h09, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     csvt_pkg::DEFAULT_DELIM};
    foreach (phase_delims[p]) run_phase(phase_delims[p], p);
    settle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
